### rtl/core/periodic_oneshot_timer_table_unit_defines.svh
// assertion macros for the timer table
`ifndef PERIODIC_ONESHOT_TIMER_TABLE_UNIT_DEFINES_SVH
`define PERIODIC_ONESHOT_TIMER_TABLE_UNIT_DEFINES_SVH

// checked on every edge outside reset
`define POTMR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define POTMR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/potmr_pkg.sv
package potmr_pkg;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_REG  = 1'b1;

	localparam logic [1:0] KIND_FIRED = 2'd0;
	localparam logic [1:0] KIND_REGD  = 2'd1;
	localparam logic [1:0] KIND_FULL  = 2'd2;
	localparam logic [1:0] KIND_ZERO  = 2'd3;

	typedef struct packed {
		logic        cmd;
		logic [31:0] period;
		logic        oneshot;
		logic [3:0]  action;
		logic [15:0] tag;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  slot;
		logic [3:0]  fired_action;
		logic [15:0] fired_tag;
		logic        last;
	} rsp_t;

endpackage

### rtl/core/potmr_ram.sv
module potmr_ram #(
	parameter int WIDTH = 85,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/periodic_oneshot_timer_table_unit.sv
// timer table: slot state in one ram, live bits in flops
// register item: busy while the live bits are scanned, one live bit checked per cycle
// zero period register item: result next cycle, never busy
// tick item: busy for the whole walk, one ram read per slot, written back when live; fires follow one by one
// each result shows for one cycle after it is decided; the receiver cannot stall
// arst_n clears all live bits at once; no clearing pass
`include "periodic_oneshot_timer_table_unit_defines.svh"

module periodic_oneshot_timer_table_unit
	import potmr_pkg::*;
#(
	parameter int SLOTS      = 16,
	parameter int COUNT_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic rsp_valid,
	output rsp_t rsp
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CB    = COUNT_BITS;
	localparam int EW    = 2 * CB + 21;
	localparam int RLD_L = 21;
	localparam int REM_L = 21 + CB;
	localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_REG  = 2'd1;
	localparam logic [1:0] ST_TICK = 2'd2;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [3:0]       action;
		logic [15:0]      tag;
	} pend_t;

	logic [1:0]       state_q;
	logic [SLOTS-1:0] live_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             rd_active_q;
	logic             valid_s2;
	logic [IDX_W-1:0] idx_s2;
	req_t             req_q;
	pend_t            pend_q;
	logic             pend_valid_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic             accept;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [EW-1:0]    ram_wdata;
	logic [EW-1:0]    ram_rdata;
	logic [CB-1:0]    dec;
	logic             fire;
	logic             walk_done;
	logic             flush;
	logic             emit;
	rsp_t             emit_rsp;
	logic [31:0]      p_sat;
	logic [IDX_W+3:0] rd_idx_ext;
	logic [IDX_W+3:0] pend_idx_ext;

	assign busy      = state_q != ST_IDLE;
	assign accept    = start && !busy;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign p_sat        = (req_q.period > CNT_MAX) ? CNT_MAX : req_q.period;
	assign rd_idx_ext   = {4'b0, rd_idx_q};
	assign pend_idx_ext = {4'b0, pend_q.idx};

	assign dec       = ram_rdata[REM_L +: CB] - CB'(1);
	assign fire      = state_q == ST_TICK && valid_s2 && live_q[idx_s2] && dec == '0;
	assign walk_done = state_q == ST_TICK && !rd_active_q && !valid_s2;
	assign flush     = walk_done && pend_valid_q;

	potmr_ram #(
		.WIDTH(EW),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_idx_q;
		ram_wdata = ram_rdata;
		emit      = 1'b0;
		emit_rsp  = '0;
		emit_rsp.last = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (accept && req.cmd == CMD_REG && req.period == '0) begin
					emit          = 1'b1;
					emit_rsp.kind = KIND_ZERO;
				end
			end
			ST_REG: begin
				if (!live_q[rd_idx_q]) begin
					ram_we        = 1'b1;
					ram_wdata     = {p_sat[CB-1:0], p_sat[CB-1:0], req_q.oneshot,
						req_q.action, req_q.tag};
					emit          = 1'b1;
					emit_rsp.kind = KIND_REGD;
					emit_rsp.slot = rd_idx_ext[3:0];
				end else if (rd_idx_q == LAST_IDX) begin
					emit          = 1'b1;
					emit_rsp.kind = KIND_FULL;
				end
			end
			ST_TICK: begin
				ram_waddr = idx_s2;
				ram_we    = valid_s2 && live_q[idx_s2];
				ram_wdata[REM_L +: CB] = (fire && !ram_rdata[20]) ?
					ram_rdata[RLD_L +: CB] : dec;
				if ((fire && pend_valid_q) || flush) begin
					emit                  = 1'b1;
					emit_rsp.kind         = KIND_FIRED;
					emit_rsp.slot         = pend_idx_ext[3:0];
					emit_rsp.fired_action = pend_q.action;
					emit_rsp.fired_tag    = pend_q.tag;
					emit_rsp.last         = flush;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			live_q       <= '0;
			rd_idx_q     <= '0;
			rd_active_q  <= 1'b0;
			valid_s2     <= 1'b0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			rsp_valid_q <= emit;
			case (state_q)
				ST_IDLE: begin
					rd_idx_q <= '0;
					if (accept) begin
						if (req.cmd == CMD_TICK) begin
							state_q     <= ST_TICK;
							rd_active_q <= 1'b1;
						end else if (req.period != '0) begin
							state_q <= ST_REG;
						end
					end
				end
				ST_REG: begin
					if (!live_q[rd_idx_q]) begin
						live_q[rd_idx_q] <= 1'b1;
						state_q          <= ST_IDLE;
					end else if (rd_idx_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				ST_TICK: begin
					valid_s2 <= rd_active_q;
					if (rd_active_q) begin
						if (rd_idx_q == LAST_IDX) begin
							rd_active_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
					if (fire) begin
						pend_valid_q <= 1'b1;
						if (ram_rdata[20]) begin
							live_q[idx_s2] <= 1'b0;
						end
					end
					if (!rd_active_q && !valid_s2) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		idx_s2 <= rd_idx_q;
		if (fire) begin
			pend_q.idx    <= idx_s2;
			pend_q.action <= ram_rdata[19:16];
			pend_q.tag    <= ram_rdata[15:0];
		end
		if (emit) begin
			rsp_q <= emit_rsp;
		end
	end

	`POTMR_ASSERT(a_accept_progress, accept |=> (busy || rsp_valid), "item not taken up")
	`POTMR_ASSERT(a_single_reply, (rsp_valid && rsp.kind != KIND_FIRED) |-> rsp.last, "reply not last")
	`POTMR_ASSERT(a_tick_ends, walk_done |=> (state_q == ST_IDLE && !pend_valid_q), "tick walk stuck")
	`POTMR_ASSERT_ALWAYS(a_idle_no_write, (state_q == ST_IDLE) |-> !ram_we, "ram written while idle")

endmodule

### verif/periodic_oneshot_timer_table_unit_test.sv
`timescale 1ns / 1ps

module periodic_oneshot_timer_table_unit_test;
	import potmr_pkg::*;

	localparam int NSLOTS = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 260;

	class timer_table_board;
		bit          live[NSLOTS];
		logic [31:0] count[NSLOTS];
		logic [31:0] reload[NSLOTS];
		bit          once[NSLOTS];
		logic [3:0]  handler[NSLOTS];
		logic [15:0] owner[NSLOTS];
		rsp_t        due_results[$];
		int          errors;

		function new();
			errors = 0;
			foreach (live[i]) live[i] = 1'b0;
		endfunction

		function void note_request(req_t r);
			rsp_t        e;
			int          fires;
			int          free_slot;
			logic [31:0] c;
			fires = 0;
			free_slot = -1;
			if (r.cmd == CMD_TICK) begin
				for (int i = 0; i < NSLOTS; i++) begin
					if (!live[i])
						continue;
					c = count[i] - 32'd1;
					if (c == 32'd0) begin
						e = '0;
						e.kind = KIND_FIRED;
						e.slot = 4'(i);
						e.fired_action = handler[i];
						e.fired_tag = owner[i];
						due_results.push_back(e);
						fires++;
						if (once[i])
							live[i] = 1'b0;
						else
							c = reload[i];
					end
					count[i] = c;
				end
				if (fires > 0) begin
					e = due_results.pop_back();
					e.last = 1'b1;
					due_results.push_back(e);
				end
			end else begin
				e = '0;
				e.last = 1'b1;
				if (r.period == 32'd0) begin
					e.kind = KIND_ZERO;
				end else begin
					for (int i = 0; i < NSLOTS; i++) begin
						if (!live[i]) begin
							free_slot = i;
							break;
						end
					end
					if (free_slot < 0) begin
						e.kind = KIND_FULL;
					end else begin
						live[free_slot] = 1'b1;
						count[free_slot] = r.period;
						reload[free_slot] = r.period;
						once[free_slot] = r.oneshot;
						handler[free_slot] = r.action;
						owner[free_slot] = r.tag;
						e.kind = KIND_REGD;
						e.slot = 4'(free_slot);
					end
				end
				due_results.push_back(e);
			end
		endfunction

		function void check_result(rsp_t a);
			rsp_t e;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result kind=%0d slot=%0d action=%0d tag=%h last=%0d",
					$time, a.kind, a.slot, a.fired_action, a.fired_tag, a.last);
				errors++;
				return;
			end
			e = due_results.pop_front();
			if (a.kind !== e.kind || a.slot !== e.slot || a.fired_action !== e.fired_action ||
			    a.fired_tag !== e.fired_tag || a.last !== e.last) begin
				$display("%0t: result mismatch expected kind=%0d slot=%0d action=%0d tag=%h last=%0d",
					$time, e.kind, e.slot, e.fired_action, e.fired_tag, e.last);
				$display("%0t:                 actual   kind=%0d slot=%0d action=%0d tag=%h last=%0d",
					$time, a.kind, a.slot, a.fired_action, a.fired_tag, a.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic rsp_valid;
	rsp_t rsp;

	timer_table_board board;
	int unsigned      cycles = 0;
	int               burst_left = 0;

	periodic_oneshot_timer_table_unit #(
		.SLOTS(NSLOTS),
		.COUNT_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** periodic_oneshot_timer_table_unit: FAILED **");
			$finish;
		end else if (arst_n) begin
			if (rsp_valid)
				board.check_result(rsp);
			if (start && !busy)
				board.note_request(req);
		end
	end

	function automatic req_t make_item(logic cmd, logic [31:0] p, logic os, logic [3:0] a,
		logic [15:0] t);
		req_t r;
		r.cmd = cmd;
		r.period = p;
		r.oneshot = os;
		r.action = a;
		r.tag = t;
		return r;
	endfunction

	function automatic req_t tick_item();
		return make_item(CMD_TICK, $urandom(), 1'($urandom()), 4'($urandom()), 16'($urandom()));
	endfunction

	function automatic req_t random_item();
		logic [31:0] p;
		int          pick;
		if ($urandom_range(0, 99) < 62)
			return tick_item();
		pick = $urandom_range(0, 99);
		if (pick < 5)
			p = 32'd0;
		else if (pick < 10)
			p = $urandom();
		else
			p = $urandom_range(1, 12);
		return make_item(CMD_REG, p, ($urandom_range(0, 99) < 85), 4'($urandom()),
			16'($urandom()));
	endfunction

	task automatic send(req_t r);
		if (burst_left == 0) begin
			start = 1'b0;
			repeat (($urandom_range(0, 3) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 3))
				@(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 8);
		end
		burst_left--;
		req = r;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero period, extremes, one-shot and periodic firing, tick with no expiry
		send(make_item(CMD_REG, 32'd0, 1'b0, 4'd3, 16'h5a5a));
		send(make_item(CMD_REG, 32'd1, 1'b1, 4'd15, 16'hffff));
		send(make_item(CMD_REG, 32'hffff_ffff, 1'b0, 4'd0, 16'h0000));
		send(make_item(CMD_REG, 32'd2, 1'b0, 4'd9, 16'h1234));
		send(tick_item());
		send(tick_item());
		send(tick_item());
		// fill the table, overflow it, then fire almost every slot in one tick
		for (int k = 0; k < NSLOTS - 2; k++)
			send(make_item(CMD_REG, 32'd1, 1'b1, 4'(k), 16'($urandom())));
		send(make_item(CMD_REG, 32'd7, 1'b0, 4'd1, 16'h00ff));
		send(tick_item());
		send(tick_item());

		for (int n = 0; n < RANDOM_ITEMS; n++)
			send(random_item());
		start = 1'b0;

		while (board.due_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0)
			$display("** periodic_oneshot_timer_table_unit: PASSED **");
		else
			$display("** periodic_oneshot_timer_table_unit: FAILED **");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/potmr_pkg.sv
rtl/core/potmr_ram.sv
rtl/core/periodic_oneshot_timer_table_unit.sv
verif/periodic_oneshot_timer_table_unit_test.sv
